// File: rtl/gbfr_pkg.sv
// gbfr_pkg: shared types and constants for the binary frame receiver
// parse phase enum, register indexes, frame codes and the result struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gbfr_pkg;

    // parse phases of the frame receiver
    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_SYNC1 = 4'd1,
        PH_CLASS = 4'd2,
        PH_ID    = 4'd3,
        PH_LENL  = 4'd4,
        PH_LENH  = 4'd5,
        PH_DATA  = 4'd6,
        PH_CKA   = 4'd7,
        PH_CKB   = 4'd8
    } phase_t;

    // configuration register indexes
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN     = 2'd2;

    // configuration reset values
    localparam logic [7:0]  SYNC_FIRST_RST  = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h62;
    localparam logic [15:0] MAX_LEN_RST     = 16'd400;

    // frame codes
    localparam logic [7:0] CLS_ACK   = 8'h05;
    localparam logic [7:0] ID_ACKACK = 8'h01;
    localparam logic [7:0] CLS_CFG   = 8'h06;
    localparam logic [7:0] CLS_NAV   = 8'h01;
    localparam logic [7:0] ID_PVT    = 8'h07;
    localparam logic [2:0] LAST_STAGE = 3'd4;

    // configuration register contents
    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] max_len;
    } cfg_t;

    // one completed frame report
    typedef struct packed {
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] payload_len;
        logic        checksum_ok;
        logic        ack_matched;
        logic [2:0]  config_stage;
        logic        nav_solution_frame;
    } result_t;

    // cfg message id expected at each ack stage: port, rate, nav engine, message
    function automatic logic [7:0] stage_cfg_id(input logic [1:0] stage);
        logic [7:0] id;
        case (stage)
            2'd0:    id = 8'h00;
            2'd1:    id = 8'h08;
            2'd2:    id = 8'h24;
            default: id = 8'h01;
        endcase
        return id;
    endfunction

endpackage

`default_nettype wire

// File: rtl/gbfr_parser.sv
// gbfr_parser: frame parse state machine, running fletcher sums and ack tracking
// one word is consumed per accepted cycle; the report is produced combinationally
// depends on gbfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module gbfr_parser
    import gbfr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       byte_en,
    input  wire logic [7:0] byte_data,
    input  wire cfg_t       cfg,
    output logic            at_ckb,
    output logic            emit,
    output result_t         result
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  rx_a_reg, rx_a_next;
    logic [7:0]  pay0_reg, pay0_next;
    logic [7:0]  pay1_reg, pay1_next;
    logic [2:0]  stage_reg, stage_next;

    logic [7:0]  add_a;
    logic [7:0]  add_b;
    logic [15:0] full_len;
    logic [15:0] count_inc;
    logic        ok;
    logic        ack_hit;

    // fletcher step on the current word
    assign add_a     = sum_a_reg + byte_data;
    assign add_b     = sum_b_reg + add_a;
    assign full_len  = {byte_data, len_reg[7:0]};
    assign count_inc = count_reg + 16'd1;

    // checksum verdict and ack match on the last checksum word
    assign ok      = (rx_a_reg == sum_a_reg) && (byte_data == sum_b_reg);
    assign ack_hit = (class_reg == CLS_ACK) && (id_reg == ID_ACKACK)
                     && (len_reg >= 16'd2) && (pay0_reg == CLS_CFG)
                     && (pay1_reg == stage_cfg_id(stage_reg[1:0]));

    assign at_ckb = (phase_reg == PH_CKB);

    // next state and report
    always_comb begin
        phase_next = phase_reg;
        class_next = class_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        count_next = count_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        rx_a_next  = rx_a_reg;
        pay0_next  = pay0_reg;
        pay1_next  = pay1_reg;
        stage_next = stage_reg;
        emit       = 1'b0;
        result     = '0;
        if (byte_en) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (byte_data == cfg.sync_first) phase_next = PH_SYNC1;
                end
                PH_SYNC1: begin
                    phase_next = (byte_data == cfg.sync_second) ? PH_CLASS : PH_HUNT;
                end
                PH_CLASS: begin
                    class_next = byte_data;
                    sum_a_next = byte_data;
                    sum_b_next = byte_data;
                    phase_next = PH_ID;
                end
                PH_ID: begin
                    id_next    = byte_data;
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    phase_next = PH_LENL;
                end
                PH_LENL: begin
                    len_next   = {8'd0, byte_data};
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    phase_next = PH_LENH;
                end
                PH_LENH: begin
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    count_next = '0;
                    if (full_len > cfg.max_len) begin
                        len_next   = '0;
                        phase_next = PH_HUNT;
                    end else begin
                        len_next   = full_len;
                        phase_next = (full_len == 16'd0) ? PH_CKA : PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (count_reg == 16'd0) pay0_next = byte_data;
                    else if (count_reg == 16'd1) pay1_next = byte_data;
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    count_next = count_inc;
                    if (count_inc >= len_reg) phase_next = PH_CKA;
                end
                PH_CKA: begin
                    rx_a_next  = byte_data;
                    phase_next = PH_CKB;
                end
                PH_CKB: begin
                    phase_next = PH_HUNT;
                    emit       = 1'b1;
                    result.msg_class   = class_reg;
                    result.msg_id      = id_reg;
                    result.payload_len = len_reg;
                    result.checksum_ok = ok;
                    if (ok && (stage_reg < LAST_STAGE) && ack_hit) begin
                        stage_next         = stage_reg + 3'd1;
                        result.ack_matched = 1'b1;
                    end
                    if (ok && (stage_reg >= LAST_STAGE) && (class_reg == CLS_NAV)
                        && (id_reg == ID_PVT)) begin
                        result.nav_solution_frame = 1'b1;
                    end
                    result.config_stage = stage_next;
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            class_reg <= '0;
            id_reg    <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            rx_a_reg  <= '0;
            pay0_reg  <= '0;
            pay1_reg  <= '0;
            stage_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            class_reg <= class_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            rx_a_reg  <= rx_a_next;
            pay0_reg  <= pay0_next;
            pay1_reg  <= pay1_next;
            stage_reg <= stage_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/gnss_binary_frame_receiver_top.sv
// Binary frame receiver top: one word per cycle, frame report on the last checksum word.
// Throughput: one word per cycle; only a checksum-B word waits for a free result register.
// Report is registered: valid in the cycle after its last checksum word is accepted.
// Words that end no frame are taken even while a report waits on the result side.
// Reset (aresetn low, synchronous): parser back to sync hunt, ack stage zero,
// result register empty, sync bytes 0xB5/0x62 and length limit 400.
// depends on gbfr_pkg and gbfr_parser
`timescale 1ns / 1ps
`default_nettype none

module gnss_binary_frame_receiver_top
    import gbfr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wr_data,
    // word input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    // frame report output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_msg_class,
    output logic [7:0]       m_msg_id,
    output logic [15:0]      m_payload_len,
    output logic             m_checksum_ok,
    output logic             m_ack_matched,
    output logic [2:0]       m_config_stage,
    output logic             m_nav_solution_frame
);

    cfg_t    cfg_reg;
    logic    valid_reg;
    result_t result_reg;
    logic    at_ckb;
    logic    emit;
    result_t result;
    logic    byte_en;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first  <= SYNC_FIRST_RST;
            cfg_reg.sync_second <= SYNC_SECOND_RST;
            cfg_reg.max_len     <= MAX_LEN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SYNC_FIRST:  cfg_reg.sync_first  <= cfg_wr_data[7:0];
                CFG_SYNC_SECOND: cfg_reg.sync_second <= cfg_wr_data[7:0];
                CFG_MAX_LEN:     cfg_reg.max_len     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // a word is refused only when it would finish a frame and the report slot is full and not being read
    assign s_ready = !at_ckb || !valid_reg || m_ready;
    assign byte_en = s_valid && s_ready;

    gbfr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (byte_en),
        .byte_data (s_rx_byte),
        .cfg       (cfg_reg),
        .at_ckb    (at_ckb),
        .emit      (emit),
        .result    (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (emit) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            result_reg <= result;
        end
    end

    assign m_valid              = valid_reg;
    assign m_msg_class          = result_reg.msg_class;
    assign m_msg_id             = result_reg.msg_id;
    assign m_payload_len        = result_reg.payload_len;
    assign m_checksum_ok        = result_reg.checksum_ok;
    assign m_ack_matched        = result_reg.ack_matched;
    assign m_config_stage       = result_reg.config_stage;
    assign m_nav_solution_frame = result_reg.nav_solution_frame;

endmodule

`default_nettype wire
